[design/i2cws_pkg.sv]
// Shared types and constants for the I2C write-frame serializer.
`default_nettype none

package i2cws_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h78;
    localparam logic [BYTE_W-1:0] CTRL_DATA  = 8'h40;
    localparam logic [BYTE_W-1:0] CTRL_CMD   = 8'h00;

    // Three bytes per frame, nine symbols per byte (eight bits and an ack).
    localparam logic [1:0] LAST_BYTE = 2'd2;
    localparam logic [3:0] ACK_POS   = 4'd8;

    localparam logic REG_DEVICE_ADDRESS = 1'b0;

    typedef enum logic [1:0] {
        SYM_START = 2'd0,
        SYM_BIT   = 2'd1,
        SYM_ACK   = 2'd2,
        SYM_STOP  = 2'd3
    } sym_kind_t;

    typedef enum logic [1:0] {
        ST_START,
        ST_BYTES,
        ST_STOP
    } frame_state_t;

    typedef struct packed {
        sym_kind_t kind;
        logic      level;
        logic      last;
    } symbol_t;

    typedef struct packed {
        frame_state_t state;
        logic [1:0]   byte_idx;
        logic [3:0]   bit_idx;
    } frame_pos_t;

endpackage

`default_nettype wire

[design/i2cws_symbol_gen.sv]
// Combinational decode of the current frame position into one bus symbol.
`default_nettype none

module i2cws_symbol_gen (
    input  wire i2cws_pkg::frame_pos_t  pos,
    input  wire [i2cws_pkg::BYTE_W-1:0] device_address,
    input  wire [i2cws_pkg::BYTE_W-1:0] payload,
    input  wire                         is_data,
    output i2cws_pkg::symbol_t          sym
);

    logic [i2cws_pkg::BYTE_W-1:0] cur_byte;
    logic [2:0]                   bit_sel;

    always_comb begin
        unique case (pos.byte_idx)
            2'd0:    cur_byte = device_address;
            2'd1:    cur_byte = is_data ? i2cws_pkg::CTRL_DATA : i2cws_pkg::CTRL_CMD;
            default: cur_byte = payload;
        endcase
    end

    // MSB first; the ack clock repeats bit 0, the last one driven.
    assign bit_sel = (pos.bit_idx == i2cws_pkg::ACK_POS) ? 3'd0 : 3'd7 - pos.bit_idx[2:0];

    always_comb begin
        unique case (pos.state)
            i2cws_pkg::ST_START: begin
                sym.kind  = i2cws_pkg::SYM_START;
                sym.level = 1'b1;
                sym.last  = 1'b0;
            end
            i2cws_pkg::ST_STOP: begin
                sym.kind  = i2cws_pkg::SYM_STOP;
                sym.level = 1'b0;
                sym.last  = 1'b1;
            end
            default: begin
                sym.kind  = (pos.bit_idx == i2cws_pkg::ACK_POS) ? i2cws_pkg::SYM_ACK
                                                                 : i2cws_pkg::SYM_BIT;
                sym.level = cur_byte[bit_sel];
                sym.last  = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/i2c_write_frame_serializer.sv]
// Top level: APB register, item register, frame sequencer and output register.
// The start symbol passes the item register and then the output register.
// Throughput: 29 output beats per item (start, 3 x (8 bits + ack), stop); the
//   frame sequencer steps one symbol per cycle when the output side takes beats.
// The next item is accepted in the cycle its predecessor's stop symbol is issued.
// Reset (aresetn, synchronous, active low) empties both registers, rewinds the
//   sequencer to the start symbol and sets device_address to 0x78.
`default_nettype none

module i2c_write_frame_serializer (
    input  wire                           aclk,
    input  wire                           aresetn,
    // configuration port
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [i2cws_pkg::PADDR_W-1:0]  paddr,
    input  wire [i2cws_pkg::PDATA_W-1:0]  pwdata,
    output logic [i2cws_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    // input channel
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire [i2cws_pkg::BYTE_W-1:0]   s_payload,
    input  wire                           s_is_data,
    // result channel
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [1:0]                    m_symbol_kind,
    output logic                          m_line_level,
    output logic                          m_last
);

    // ---------------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------------
    logic [i2cws_pkg::BYTE_W-1:0] dev_addr_reg;
    logic                         cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == i2cws_pkg::REG_DEVICE_ADDRESS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= i2cws_pkg::ADDR_RESET;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            dev_addr_reg <= pwdata[i2cws_pkg::BYTE_W-1:0];
        end
    end

    // Low address bits are don't-care; anything past the register reads zero.
    assign prdata = cfg_hit ? {{(i2cws_pkg::PDATA_W-i2cws_pkg::BYTE_W){1'b0}}, dev_addr_reg}
                            : '0;

    // ---------------------------------------------------------------------
    // Item register and frame sequencer
    // ---------------------------------------------------------------------
    logic                         item_valid_reg, item_valid_next;
    logic [i2cws_pkg::BYTE_W-1:0] payload_reg;
    logic                         is_data_reg;
    i2cws_pkg::frame_pos_t        pos_reg, pos_next;
    i2cws_pkg::symbol_t           sym;
    logic                         advance;
    logic                         frame_done;
    logic                         s_accept;

    // Issue a symbol whenever an item is held and the output register frees up.
    assign advance    = item_valid_reg && (!m_valid || m_ready);
    assign frame_done = advance && (pos_reg.state == i2cws_pkg::ST_STOP);
    assign s_ready    = !item_valid_reg || frame_done;
    assign s_accept   = s_valid && s_ready;

    always_comb begin
        pos_next        = pos_reg;
        item_valid_next = item_valid_reg;
        if (advance) begin
            unique case (pos_reg.state)
                i2cws_pkg::ST_START: begin
                    pos_next.state    = i2cws_pkg::ST_BYTES;
                    pos_next.byte_idx = 2'd0;
                    pos_next.bit_idx  = 4'd0;
                end
                i2cws_pkg::ST_BYTES: begin
                    if (pos_reg.bit_idx == i2cws_pkg::ACK_POS) begin
                        pos_next.bit_idx = 4'd0;
                        if (pos_reg.byte_idx == i2cws_pkg::LAST_BYTE) begin
                            pos_next.state = i2cws_pkg::ST_STOP;
                        end else begin
                            pos_next.byte_idx = pos_reg.byte_idx + 2'd1;
                        end
                    end else begin
                        pos_next.bit_idx = pos_reg.bit_idx + 4'd1;
                    end
                end
                default: begin
                    // Stop issued: rewind for the next frame.
                    pos_next.state    = i2cws_pkg::ST_START;
                    pos_next.byte_idx = 2'd0;
                    pos_next.bit_idx  = 4'd0;
                    item_valid_next   = 1'b0;
                end
            endcase
        end
        if (s_accept) begin
            item_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg   <= 1'b0;
            pos_reg.state    <= i2cws_pkg::ST_START;
            pos_reg.byte_idx <= 2'd0;
            pos_reg.bit_idx  <= 4'd0;
        end else begin
            item_valid_reg <= item_valid_next;
            pos_reg        <= pos_next;
        end
    end

    // Payload holds while the frame is in flight.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            payload_reg <= s_payload;
            is_data_reg <= s_is_data;
        end
    end

    i2cws_symbol_gen u_symbol_gen (
        .pos            (pos_reg),
        .device_address (dev_addr_reg),
        .payload        (payload_reg),
        .is_data        (is_data_reg),
        .sym            (sym)
    );

    // ---------------------------------------------------------------------
    // Output register: one symbol per beat
    // ---------------------------------------------------------------------
    logic               m_valid_reg;
    i2cws_pkg::symbol_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= sym;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_symbol_kind = out_reg.kind;
    assign m_line_level  = out_reg.level;
    assign m_last        = out_reg.last;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // No new item may land while a frame is still short of its stop symbol.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid_reg && pos_reg.state != i2cws_pkg::ST_STOP) |-> !s_ready)
        else $error("input accepted mid-frame");

    // The frame end marker rides only on the stop symbol.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_symbol_kind == i2cws_pkg::SYM_STOP))
        else $error("last flag on a non-stop symbol");

    // A start symbol always follows an issued stop when the next frame begins.
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |=> (pos_reg.state == i2cws_pkg::ST_START))
        else $error("sequencer did not rewind after stop");

    // Sequencer counters stay within a byte's nine symbols and three bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg.bit_idx <= i2cws_pkg::ACK_POS) && (pos_reg.byte_idx <= i2cws_pkg::LAST_BYTE))
        else $error("frame position out of range");

endmodule

`default_nettype wire
